// ===== rtl/core/rsc_pkg.sv =====
`default_nettype none
package rsc_pkg;

    // Store geometry.
    localparam int STORE_BYTES = 1024;
    localparam int NAME_MAX    = 32;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    // Chain pointers may run past the end of the store by up to one span.
    localparam int PTR_W       = (ADDR_W + 1 > 11) ? ADDR_W + 1 : 11;
    localparam int SL_W        = $clog2(NAME_MAX + 1);
    localparam int SB_AW       = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
    localparam int SPAN_W      = 9;
    localparam int COUNT_W     = 10;

    // Record kind bytes.
    localparam logic [7:0] KIND_LIVE   = 8'h00;
    localparam logic [7:0] KIND_ERASED = 8'hFF;

    // Function codes.
    localparam logic [2:0] FN_APPEND = 3'd0;
    localparam logic [2:0] FN_ERASE  = 3'd1;
    localparam logic [2:0] FN_GET    = 3'd2;
    localparam logic [2:0] FN_CLEAR  = 3'd3;
    localparam logic [2:0] FN_WRITE  = 3'd4;
    localparam logic [2:0] FN_READ   = 3'd5;

    // Status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_SPACE   = 3'd1;
    localparam logic [2:0] ST_NO_RECORDS = 3'd2;
    localparam logic [2:0] ST_TOO_BIG    = 3'd3;
    localparam logic [2:0] ST_CORRUPT    = 3'd4;

endpackage
`default_nettype wire

// ===== rtl/core/rsc_ram.sv =====
`default_nettype none
module rsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/record_store_compactor.sv =====
`default_nettype none
// Record store with compaction. A command is taken when start is high and busy is
// low; its single result appears for exactly one cycle with done high and must be
// captured then, since the block cannot be stalled. Commands reach the byte store
// through its one write port and one registered read port; get and append walk it
// and clear sweeps it. Raw write, erase, an append byte that is not the last and the
// unused codes finish without leaving idle, so busy stays low for the next command.
// Read waits for the registered read byte; get reads the length and kind of each
// header it visits. The last append byte pays for compaction, reading the length and
// kind of each record walked and copying each byte moved with a read and a write,
// then a recount of the chain, then writes of the name bytes, the terminator and
// the header. Clear sweeps the store one byte a cycle. After reset the same clearing
// pass runs with busy high before the first command is taken.
module record_store_compactor (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [2:0]          func,
    input  wire logic [7:0]          data_byte,
    input  wire logic                last,
    input  wire logic [9:0]          address,
    input  wire logic [8:0]          nth,
    output logic                     done,
    output logic [2:0]               status,
    output logic                     found,
    output logic [9:0]               record_address,
    output logic [9:0]               entry_count,
    output logic [7:0]               read_data
);
    import rsc_pkg::*;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_RDW,
        S_GH, S_GL, S_GK,
        S_CH, S_CL, S_CK, S_CPR, S_CPW, S_CE, S_CT,
        S_RH, S_RL,
        S_AC, S_ARD, S_AWR, S_AT0, S_AT1, S_AH0, S_AH1
    } state_t;

    localparam logic [PTR_W-1:0] STORE_END = PTR_W'(STORE_BYTES);
    localparam logic [SPAN_W-1:0] SPAN_LIMIT = SPAN_W'(NAME_MAX + 3);

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   p_reg, p_next;
    logic [PTR_W-1:0]   dst_reg, dst_next;
    logic               sliding_reg, sliding_next;
    logic [SPAN_W-1:0]  span_reg, span_next;
    logic [SPAN_W-1:0]  i_reg, i_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [8:0]         k_reg, k_next;
    logic [SL_W-1:0]    sl_reg, sl_next;
    logic [SL_W-1:0]    n_reg, n_next;
    logic               report_reg, report_next;
    logic               rd_oor_reg;
    logic               done_reg, done_next;
    logic [2:0]         status_reg, status_next;
    logic               found_reg, found_next;
    logic [9:0]         raddr_reg, raddr_next;
    logic [7:0]         rdata_reg, rdata_next;

    // Memory control.
    logic [PTR_W-1:0]   rd_ptr;
    logic               wr_req;
    logic [PTR_W-1:0]   wr_ptr;
    logic [7:0]         wr_data;
    logic [7:0]         store_q;
    logic [7:0]         rbyte;
    logic               sb_we;
    logic [SB_AW-1:0]   sb_raddr;
    logic [7:0]         sb_q;
    logic [PTR_W-1:0]   addr_ext;
    logic [SL_W-1:0]    n_new;
    logic [PTR_W-1:0]   span_ext;

    rsc_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
        .clk   (clk),
        .we    (wr_req && (wr_ptr < STORE_END)),
        .waddr (wr_ptr[ADDR_W-1:0]),
        .wdata (wr_data),
        .raddr (rd_ptr[ADDR_W-1:0]),
        .rdata (store_q)
    );

    rsc_ram #(.WIDTH(8), .DEPTH(NAME_MAX)) u_staging (
        .clk   (clk),
        .we    (sb_we),
        .waddr (sl_reg[SB_AW-1:0]),
        .wdata (data_byte),
        .raddr (sb_raddr),
        .rdata (sb_q)
    );

    // Bytes beyond the store read as zero.
    assign rbyte    = rd_oor_reg ? 8'h00 : store_q;
    assign addr_ext = PTR_W'(address);
    assign n_new    = (sl_reg < SL_W'(NAME_MAX)) ? sl_reg + SL_W'(1) : sl_reg;
    assign span_ext = PTR_W'(span_reg);

    // Sequencer next-state and memory control.
    always_comb
    begin
        state_next   = state_reg;
        p_next       = p_reg;
        dst_next     = dst_reg;
        sliding_next = sliding_reg;
        span_next    = span_reg;
        i_next       = i_reg;
        count_next   = count_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        sl_next      = sl_reg;
        n_next       = n_reg;
        report_next  = report_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        found_next   = found_reg;
        raddr_next   = raddr_reg;
        rdata_next   = rdata_reg;
        rd_ptr       = p_reg;
        wr_req       = 1'b0;
        wr_ptr       = p_reg;
        wr_data      = 8'h00;
        sb_we        = 1'b0;
        sb_raddr     = i_reg[SB_AW-1:0];

        unique case (state_reg)
            S_CLR:
            begin
                wr_req = 1'b1;
                wr_ptr = p_reg;
                p_next = p_reg + PTR_W'(1);
                if (p_reg == STORE_END - PTR_W'(1))
                begin
                    state_next = S_IDLE;
                    if (report_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        found_next  = 1'b0;
                        raddr_next  = '0;
                        rdata_next  = '0;
                    end
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    // Default result of a transaction that finishes at once.
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    raddr_next  = '0;
                    rdata_next  = '0;
                    case (func)
                        FN_APPEND:
                        begin
                            if (sl_reg < SL_W'(NAME_MAX))
                            begin
                                sb_we   = 1'b1;
                                sl_next = sl_reg + SL_W'(1);
                            end
                            if (last)
                            begin
                                sl_next      = '0;
                                n_next       = n_new;
                                p_next       = '0;
                                dst_next     = '0;
                                sliding_next = 1'b0;
                                state_next   = S_CH;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        FN_ERASE:
                        begin
                            done_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = ST_NO_RECORDS;
                            end
                            else
                            begin
                                wr_req     = 1'b1;
                                wr_ptr     = addr_ext + PTR_W'(1);
                                wr_data    = KIND_ERASED;
                                count_next = count_reg - COUNT_W'(1);
                            end
                        end
                        FN_GET:
                        begin
                            p_next     = '0;
                            k_next     = nth;
                            state_next = S_GH;
                        end
                        FN_CLEAR:
                        begin
                            p_next      = '0;
                            report_next = 1'b1;
                            state_next  = S_CLR;
                        end
                        FN_WRITE:
                        begin
                            done_next = 1'b1;
                            wr_req    = 1'b1;
                            wr_ptr    = addr_ext;
                            wr_data   = data_byte;
                        end
                        FN_READ:
                        begin
                            rd_ptr     = addr_ext;
                            state_next = S_RDW;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_RDW:
            begin
                rdata_next = rbyte;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            // Get: walk headers, counting live records.
            S_GH:
            begin
                rd_ptr = p_reg;
                if (p_reg >= STORE_END)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_GL;
                end
            end
            S_GL:
            begin
                rd_ptr    = p_reg + PTR_W'(1);
                span_next = SPAN_W'(rbyte) + SPAN_W'(2);
                if (rbyte == 8'h00)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_GK;
                end
            end
            S_GK:
            begin
                p_next     = p_reg + span_ext;
                state_next = S_GH;
                if (rbyte != KIND_ERASED)
                begin
                    if (k_reg == '0)
                    begin
                        found_next = 1'b1;
                        raddr_next = p_reg[9:0];
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg - 9'd1;
                    end
                end
            end
            // Compaction: slide live records down over erased ones.
            S_CH:
            begin
                rd_ptr = p_reg;
                if (p_reg >= STORE_END)
                begin
                    state_next = S_CE;
                end
                else
                begin
                    state_next = S_CL;
                end
            end
            S_CL:
            begin
                rd_ptr    = p_reg + PTR_W'(1);
                span_next = SPAN_W'(rbyte) + SPAN_W'(2);
                if (rbyte == 8'h00)
                begin
                    state_next = S_CE;
                end
                else if (SPAN_W'(rbyte) + SPAN_W'(2) >= SPAN_LIMIT)
                begin
                    status_next = ST_TOO_BIG;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_CK;
                end
            end
            S_CK:
            begin
                if (rbyte == KIND_LIVE)
                begin
                    if (sliding_reg)
                    begin
                        i_next     = '0;
                        state_next = S_CPR;
                    end
                    else
                    begin
                        p_next     = p_reg + span_ext;
                        state_next = S_CH;
                    end
                end
                else if (rbyte == KIND_ERASED)
                begin
                    if (!sliding_reg)
                    begin
                        sliding_next = 1'b1;
                        dst_next     = p_reg;
                    end
                    p_next     = p_reg + span_ext;
                    state_next = S_CH;
                end
                else
                begin
                    status_next = ST_CORRUPT;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_CPR:
            begin
                rd_ptr     = p_reg + PTR_W'(i_reg);
                state_next = S_CPW;
            end
            S_CPW:
            begin
                wr_req  = 1'b1;
                wr_ptr  = dst_reg + PTR_W'(i_reg);
                wr_data = rbyte;
                i_next  = i_reg + SPAN_W'(1);
                if (i_reg + SPAN_W'(1) == span_reg)
                begin
                    dst_next   = dst_reg + span_ext;
                    p_next     = p_reg + span_ext;
                    state_next = S_CH;
                end
                else
                begin
                    state_next = S_CPR;
                end
            end
            S_CE:
            begin
                if (p_reg >= STORE_END || dst_reg >= STORE_END)
                begin
                    status_next = ST_NO_SPACE;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (sliding_reg)
                begin
                    wr_req     = 1'b1;
                    wr_ptr     = dst_reg;
                    state_next = S_CT;
                end
                else
                begin
                    p_next     = '0;
                    cnt_next   = '0;
                    state_next = S_RH;
                end
            end
            S_CT:
            begin
                wr_req     = 1'b1;
                wr_ptr     = dst_reg + PTR_W'(1);
                wr_data    = KIND_LIVE;
                p_next     = '0;
                cnt_next   = '0;
                state_next = S_RH;
            end
            // Recount; the walk also leaves p at the end of the chain.
            S_RH:
            begin
                rd_ptr = p_reg;
                if (p_reg >= STORE_END)
                begin
                    count_next = cnt_reg;
                    state_next = S_AC;
                end
                else
                begin
                    state_next = S_RL;
                end
            end
            S_RL:
            begin
                if (rbyte == 8'h00)
                begin
                    count_next = cnt_reg;
                    state_next = S_AC;
                end
                else
                begin
                    p_next     = p_reg + PTR_W'(rbyte) + PTR_W'(2);
                    cnt_next   = cnt_reg + COUNT_W'(1);
                    state_next = S_RH;
                end
            end
            // Append the staged record after the chain end.
            S_AC:
            begin
                i_next = '0;
                if (p_reg + PTR_W'(n_reg) + PTR_W'(4) > STORE_END)
                begin
                    status_next = ST_NO_SPACE;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (n_reg == '0)
                begin
                    state_next = S_AT0;
                end
                else
                begin
                    state_next = S_ARD;
                end
            end
            S_ARD:
            begin
                sb_raddr   = i_reg[SB_AW-1:0];
                state_next = S_AWR;
            end
            S_AWR:
            begin
                wr_req  = 1'b1;
                wr_ptr  = p_reg + PTR_W'(2) + PTR_W'(i_reg);
                wr_data = sb_q;
                i_next  = i_reg + SPAN_W'(1);
                if (i_reg + SPAN_W'(1) == SPAN_W'(n_reg))
                begin
                    state_next = S_AT0;
                end
                else
                begin
                    state_next = S_ARD;
                end
            end
            S_AT0:
            begin
                wr_req     = 1'b1;
                wr_ptr     = p_reg + PTR_W'(2) + PTR_W'(n_reg);
                state_next = S_AT1;
            end
            S_AT1:
            begin
                wr_req     = 1'b1;
                wr_ptr     = p_reg + PTR_W'(3) + PTR_W'(n_reg);
                wr_data    = KIND_LIVE;
                state_next = S_AH0;
            end
            S_AH0:
            begin
                wr_req     = 1'b1;
                wr_ptr     = p_reg;
                wr_data    = 8'(n_reg);
                state_next = S_AH1;
            end
            S_AH1:
            begin
                wr_req      = 1'b1;
                wr_ptr      = p_reg + PTR_W'(1);
                wr_data     = KIND_LIVE;
                count_next  = count_reg + COUNT_W'(1);
                status_next = ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            p_reg       <= '0;
            sliding_reg <= 1'b0;
            count_reg   <= '0;
            sl_reg      <= '0;
            report_reg  <= 1'b0;
            rd_oor_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_reg       <= p_next;
            sliding_reg <= sliding_next;
            count_reg   <= count_next;
            sl_reg      <= sl_next;
            report_reg  <= report_next;
            rd_oor_reg  <= (rd_ptr >= STORE_END);
            done_reg    <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        dst_reg    <= dst_next;
        span_reg   <= span_next;
        i_reg      <= i_next;
        cnt_reg    <= cnt_next;
        k_reg      <= k_next;
        n_reg      <= n_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        raddr_reg  <= raddr_next;
        rdata_reg  <= rdata_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign found          = found_reg;
    assign record_address = raddr_reg;
    assign entry_count    = count_reg;
    assign read_data      = rdata_reg;

endmodule
`default_nettype wire
